>>> hdl/midi_event_byte_encoder_top_assert.svh
//------------------------------------------------------------------------------
// MIDI event byte encoder assertion macros
// Concurrent check helpers, clocked on clk and disabled during reset.
//------------------------------------------------------------------------------
`ifndef MIDI_EVENT_BYTE_ENCODER_TOP_ASSERT_SVH
`define MIDI_EVENT_BYTE_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define MEBE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("midi_event_byte_encoder: assertion failed");

// next-cycle implication
`define MEBE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("midi_event_byte_encoder: assertion failed");

`endif

>>> hdl/mebe_pkg.sv
//------------------------------------------------------------------------------
// mebe_pkg
// Shared types and constants of the MIDI event byte encoder.
//------------------------------------------------------------------------------
package mebe_pkg;

	localparam int DELTA_W = 28;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [DELTA_W-1:0] DELTA_MAX = 28'hFFF_FFFF;

	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;
	localparam logic [1:0] OP_PROGRAM  = 2'd2;

	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;

	localparam int VLQ_SHIFT_HIGH = 21;
	localparam int VLQ_SHIFT_MID  = 14;
	localparam int VLQ_SHIFT_LOW  = 7;

	// one classified event, ready for serialization
	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		logic [7:0]         status;
		logic               send_status;
		logic               is_note;
		logic [6:0]         data0;
		logic [6:0]         data1;
	} event_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VLQ3,
		ST_VLQ2,
		ST_VLQ1,
		ST_VLQ0,
		ST_STATUS,
		ST_DATA0,
		ST_DATA1
	} ser_state_t;

endpackage

>>> hdl/mebe_front.sv
//------------------------------------------------------------------------------
// mebe_front
// Accepts track events, keeps the pending delta and running status, and
// pushes emitted events into the queue.
//------------------------------------------------------------------------------
module mebe_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [55:0]                    s_tdata,
	input  mebe_pkg::q_stat_t              q_stat,
	output logic                           push,
	output mebe_pkg::event_t               push_data
);

	logic [1:0]                   op;
	logic [3:0]                   channel;
	logic signed [7:0]            note;
	logic [6:0]                   velocity;
	logic [6:0]                   patch;
	logic [mebe_pkg::DELTA_W-1:0] ticks;

	logic [mebe_pkg::DELTA_W-1:0] pending_q;
	logic [7:0]                   last_status_q;

	logic [mebe_pkg::DELTA_W:0]   sum;
	logic [mebe_pkg::DELTA_W-1:0] delta_sat;
	logic [7:0]                   status;
	logic                         is_note;
	logic                         emit;
	logic                         accept;

	assign op       = s_tdata[1:0];
	assign channel  = s_tdata[5:2];
	assign note     = s_tdata[13:6];
	assign velocity = s_tdata[20:14];
	assign patch    = s_tdata[27:21];
	assign ticks    = s_tdata[55:28];

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		sum       = {1'b0, pending_q} + {1'b0, ticks};
		delta_sat = sum[mebe_pkg::DELTA_W] ? mebe_pkg::DELTA_MAX : sum[mebe_pkg::DELTA_W-1:0];
		status    = 8'h00;
		is_note   = 1'b0;
		emit      = 1'b0;
		unique case (op)
			mebe_pkg::OP_NOTE_ON: begin
				status  = mebe_pkg::STATUS_NOTE_ON | {4'h0, channel};
				is_note = 1'b1;
				emit    = (note >= 0);
			end
			mebe_pkg::OP_NOTE_OFF: begin
				status  = mebe_pkg::STATUS_NOTE_OFF | {4'h0, channel};
				is_note = 1'b1;
				emit    = (note >= 0);
			end
			mebe_pkg::OP_PROGRAM: begin
				status = mebe_pkg::STATUS_PROGRAM | {4'h0, channel};
				emit   = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push = accept && emit;

	always_comb begin
		push_data.delta       = delta_sat;
		push_data.status      = status;
		push_data.send_status = (status != last_status_q);
		push_data.is_note     = is_note;
		push_data.data0       = is_note ? note[6:0] : patch;
		push_data.data1       = velocity;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			last_status_q <= '0;
		end else if (accept) begin
			if (emit) begin
				pending_q     <= '0;
				last_status_q <= status;
			end else begin
				pending_q <= delta_sat;
			end
		end
	end

endmodule

>>> hdl/mebe_queue.sv
//------------------------------------------------------------------------------
// mebe_queue
// Short event queue between the front and the byte serializer.
//------------------------------------------------------------------------------
module mebe_queue #(
	parameter int QUEUE_DEPTH = mebe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mebe_pkg::event_t   push_data,
	input  logic               pop,
	output mebe_pkg::event_t   head,
	output mebe_pkg::q_stat_t  q_stat
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	mebe_pkg::event_t entries_q [QUEUE_DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign head         = entries_q[rptr_q];
	assign q_stat.full  = (count_q == CW'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wrap_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= wrap_inc(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/mebe_back.sv
//------------------------------------------------------------------------------
// mebe_back
// Byte serializer: walks one event through delta, status and data bytes
// and drives the registered output stream.
//------------------------------------------------------------------------------
module mebe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mebe_pkg::event_t   head,
	input  mebe_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	mebe_pkg::ser_state_t state_q;
	mebe_pkg::ser_state_t state_next;
	mebe_pkg::event_t     cur_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       advance;
	logic       last_byte;
	logic       load;
	logic [7:0] cur_byte;

	function automatic mebe_pkg::ser_state_t first_state(
		input logic [mebe_pkg::DELTA_W-1:0] t
	);
		mebe_pkg::ser_state_t s;
		if ((t >> mebe_pkg::VLQ_SHIFT_HIGH) != '0) begin
			s = mebe_pkg::ST_VLQ3;
		end else if ((t >> mebe_pkg::VLQ_SHIFT_MID) != '0) begin
			s = mebe_pkg::ST_VLQ2;
		end else if ((t >> mebe_pkg::VLQ_SHIFT_LOW) != '0) begin
			s = mebe_pkg::ST_VLQ1;
		end else begin
			s = mebe_pkg::ST_VLQ0;
		end
		return s;
	endfunction

	assign advance   = (state_q != mebe_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign last_byte = (state_q == mebe_pkg::ST_DATA1) ||
	                   (state_q == mebe_pkg::ST_DATA0 && !cur_q.is_note);
	assign load      = !q_stat.empty &&
	                   ((state_q == mebe_pkg::ST_IDLE) || (advance && last_byte));
	assign pop       = load;

	always_comb begin
		state_next = state_q;
		cur_byte   = 8'h00;
		unique case (state_q)
			mebe_pkg::ST_IDLE: begin
				cur_byte = 8'h00;
			end
			mebe_pkg::ST_VLQ3: begin
				cur_byte = {1'b1, cur_q.delta[27:21]};
				if (advance) state_next = mebe_pkg::ST_VLQ2;
			end
			mebe_pkg::ST_VLQ2: begin
				cur_byte = {1'b1, cur_q.delta[20:14]};
				if (advance) state_next = mebe_pkg::ST_VLQ1;
			end
			mebe_pkg::ST_VLQ1: begin
				cur_byte = {1'b1, cur_q.delta[13:7]};
				if (advance) state_next = mebe_pkg::ST_VLQ0;
			end
			mebe_pkg::ST_VLQ0: begin
				cur_byte = {1'b0, cur_q.delta[6:0]};
				if (advance) begin
					state_next = cur_q.send_status ? mebe_pkg::ST_STATUS : mebe_pkg::ST_DATA0;
				end
			end
			mebe_pkg::ST_STATUS: begin
				cur_byte = cur_q.status;
				if (advance) state_next = mebe_pkg::ST_DATA0;
			end
			mebe_pkg::ST_DATA0: begin
				cur_byte = {1'b0, cur_q.data0};
				if (advance) begin
					state_next = cur_q.is_note ? mebe_pkg::ST_DATA1 : mebe_pkg::ST_IDLE;
				end
			end
			mebe_pkg::ST_DATA1: begin
				cur_byte = {1'b0, cur_q.data1};
				if (advance) state_next = mebe_pkg::ST_IDLE;
			end
			default: begin
				state_next = mebe_pkg::ST_IDLE;
			end
		endcase
		// next event starts right behind the last byte of the current one
		if (load) begin
			state_next = first_state(head.delta);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mebe_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= cur_byte;
			out_last_q <= last_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hdl/midi_event_byte_encoder_top.sv
//------------------------------------------------------------------------------
// midi_event_byte_encoder_top
// Standard MIDI file track event writer with running status.
//------------------------------------------------------------------------------
// Each accepted transaction carries one note on, note off or program change
// event plus the ticks elapsed since the previous one. The front stage adds
// the ticks to a saturating pending delta, decides whether the event is
// emitted and whether its status byte differs from the running status, and
// queues it. The back stage sends the delta as a 1 to 4 byte variable-length
// quantity, the optional status byte and the data bytes, one byte per cycle
// while m_tready is high, with tlast on the final byte of the event. An event
// is 2 to 7 bytes long; input transactions are taken every cycle while the
// event queue has room, and items that emit nothing produce no output bytes.
//------------------------------------------------------------------------------
`include "midi_event_byte_encoder_top_assert.svh"

module midi_event_byte_encoder_top #(
	parameter int QUEUE_DEPTH = mebe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[1:0], channel[5:2], note[13:6], velocity[20:14], patch[27:21],
	// elapsed_ticks[55:28]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	mebe_pkg::q_stat_t q_stat;
	mebe_pkg::event_t  push_data;
	mebe_pkg::event_t  head;
	logic              push;
	logic              pop;

	mebe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mebe_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	mebe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`MEBE_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
	`MEBE_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)
	`MEBE_ASSERT_NEXT(a_push_not_empty, push && !pop, !q_stat.empty)

endmodule
